FILE: src/cc3_pkg.sv
package cc3_pkg;

    // coordinate format shared by the input points and the result
    localparam int COORD_W  = 32;
    localparam int NPOINT   = 3;
    localparam int IN_W     = NPOINT * 3 * COORD_W;
    localparam int OUT_W    = 3 * COORD_W;

    // exact intermediate widths
    localparam int DIFF_W   = COORD_W + 1;          // edge vectors a, b
    localparam int PRD_W    = 2 * DIFF_W;           // edge products
    localparam int CRS_W    = PRD_W + 1;            // normal n = a x b
    localparam int TPRD_W   = 2 * COORD_W;          // point products
    localparam int T_W      = TPRD_W + 1;           // p2 x p3
    localparam int SQ_W     = PRD_W + 2;            // |a|^2, |b|^2

    // split multiplier: 102 x 68 signed, 34-bit limbs
    localparam int LIMB_W   = 34;
    localparam int MA_W     = 3 * LIMB_W;
    localparam int MB_W     = 2 * LIMB_W;
    localparam int PP_W     = 2 * (LIMB_W + 1);
    localparam int MP_W     = MA_W + MB_W;

    // divider widths
    localparam int NN_W     = 2 * CRS_W - 2;        // |n|^2
    localparam int DEN_W    = NN_W + 4;             // 4 |n|^2
    localparam int MAG_W    = MP_W - 1;
    localparam int NUMER_W  = MAG_W + 2;
    localparam int QB       = 2 * COORD_W - 2;      // quotient bits kept
    localparam int REM_W    = DEN_W;
    localparam int SUM_W    = QB + 2;

    // pipeline depth in stages
    localparam int GEOM_LAT = 12;
    localparam int DIV_LAT  = QB + 1;
    localparam int PIPE_LAT = GEOM_LAT + DIV_LAT + 1;

    localparam logic signed [SUM_W-1:0] OUT_MAX =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SINGULAR,
        ST_COLLINEAR,
        ST_SATURATED
    } status_t;

    typedef struct packed {
        logic colin;
        logic sing;
    } flags_t;

    // side data that travels with one center component through the divider
    typedef struct packed {
        coord_t p0;
        logic   neg;
        flags_t flags;
    } tag_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;
        status_t                 status;
    } result_t;

endpackage

FILE: src/cc3_mul.sv
// Signed 102 x 68 multiplier from six 35 x 35 limb products, three stages.
module cc3_mul (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [cc3_pkg::MA_W-1:0]   a,
    input  logic signed [cc3_pkg::MB_W-1:0]   b,
    output logic signed [cc3_pkg::MP_W-1:0]   p
);
    import cc3_pkg::*;

    logic signed [LIMB_W:0] al [3];
    logic signed [LIMB_W:0] bl [2];
    logic signed [PP_W-1:0] pp_reg [3][2];
    logic signed [MP_W-1:0] row_reg [2];
    logic signed [MP_W-1:0] p_reg;

    // low limbs unsigned, top limb carries the sign
    assign al[0] = {1'b0, a[LIMB_W-1:0]};
    assign al[1] = {1'b0, a[2*LIMB_W-1:LIMB_W]};
    assign al[2] = {a[MA_W-1], a[MA_W-1:2*LIMB_W]};
    assign bl[0] = {1'b0, b[LIMB_W-1:0]};
    assign bl[1] = {b[MB_W-1], b[MB_W-1:LIMB_W]};

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 2; j++) begin
                    pp_reg[i][j] <= al[i] * bl[j];
                end
            end
            // one row per limb of b
            for (int j = 0; j < 2; j++) begin
                row_reg[j] <= MP_W'(pp_reg[0][j])
                            + (MP_W'(pp_reg[1][j]) <<< LIMB_W)
                            + (MP_W'(pp_reg[2][j]) <<< (2 * LIMB_W));
            end
            p_reg <= row_reg[0] + (row_reg[1] <<< LIMB_W);
        end
    end

    assign p = p_reg;

endmodule

FILE: src/cc3_geom.sv
// Geometry front end: edge vectors, normal, Cramer determinant, and the
// signed numerators of the center offset. Twelve stages.
module cc3_geom (
    input  logic                               aclk,
    input  logic                               en,
    input  cc3_pkg::coord_t                    pt [3][3],
    output logic        [cc3_pkg::MAG_W-1:0]   mag [3],
    output logic        [cc3_pkg::NN_W-1:0]    nn,
    output cc3_pkg::tag_t                      tag [3]
);
    import cc3_pkg::*;

    // G1
    logic signed [DIFF_W-1:0] a_reg [3], b_reg [3];
    coord_t                   p0_reg [3], p1_reg [3], p2_reg [3];
    // G2
    logic signed [PRD_W-1:0]  nprd_reg [3][2];
    logic signed [TPRD_W-1:0] tprd_reg [3][2];
    logic signed [PRD_W-1:0]  asq_reg [3], bsq_reg [3];
    logic signed [DIFF_W-1:0] a2_reg [3], b2_reg [3];
    coord_t                   p02_reg [3];
    // G3
    logic signed [CRS_W-1:0]  n_reg [3];
    logic signed [T_W-1:0]    t_reg [3];
    logic signed [SQ_W-1:0]   aa_reg, bb_reg;
    logic signed [DIFF_W-1:0] a3_reg [3], b3_reg [3];
    coord_t                   p03_reg [3];
    // side data alongside the first multiplier bank
    logic signed [SQ_W-1:0]   maa_reg [3], mbb_reg [3];
    coord_t                   mp0_reg [3][3];
    logic                     mcol_reg [3];
    logic                     colin;
    // multiplier outputs
    logic signed [MP_W-1:0]   det_p [3], nn_p [3];
    logic signed [MP_W-1:0]   bn_p [3][2], na_p [3][2];
    logic signed [MP_W-1:0]   num_p [3][2];
    logic signed [MP_W-1:0]   det_sum;
    // G7
    logic signed [MA_W-1:0]   bn_reg [3], na_reg [3];
    logic        [NN_W-1:0]   nn7_reg;
    flags_t                   fl7_reg;
    logic signed [SQ_W-1:0]   aa7_reg, bb7_reg;
    coord_t                   p07_reg [3];
    // side data alongside the second multiplier bank
    logic        [NN_W-1:0]   nnd_reg [3];
    flags_t                   fld_reg [3];
    coord_t                   p0d_reg [3][3];
    // G11
    logic signed [MP_W-1:0]   num_reg [3];
    logic        [NN_W-1:0]   nn11_reg;
    flags_t                   fl11_reg;
    coord_t                   p011_reg [3];
    // G12
    logic        [MAG_W-1:0]  mag_reg [3];
    logic        [NN_W-1:0]   nn12_reg;
    tag_t                     tag_reg [3];

    // G1: edge vectors relative to the first point
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k]  <= DIFF_W'(pt[1][k]) - DIFF_W'(pt[0][k]);
                b_reg[k]  <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[0][k]);
                p0_reg[k] <= pt[0][k];
                p1_reg[k] <= pt[1][k];
                p2_reg[k] <= pt[2][k];
            end
        end
    end

    // G2 / G3: cross products and squared lengths
    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_ff @(posedge aclk) begin
            if (en) begin
                nprd_reg[k][0] <= a_reg[K1] * b_reg[K2];
                nprd_reg[k][1] <= a_reg[K2] * b_reg[K1];
                tprd_reg[k][0] <= p1_reg[K1] * p2_reg[K2];
                tprd_reg[k][1] <= p1_reg[K2] * p2_reg[K1];
                asq_reg[k]     <= a_reg[k] * a_reg[k];
                bsq_reg[k]     <= b_reg[k] * b_reg[k];
                a2_reg[k]      <= a_reg[k];
                b2_reg[k]      <= b_reg[k];
                p02_reg[k]     <= p0_reg[k];

                n_reg[k]   <= CRS_W'(nprd_reg[k][0]) - CRS_W'(nprd_reg[k][1]);
                t_reg[k]   <= T_W'(tprd_reg[k][0]) - T_W'(tprd_reg[k][1]);
                a3_reg[k]  <= a2_reg[k];
                b3_reg[k]  <= b2_reg[k];
                p03_reg[k] <= p02_reg[k];
            end
        end

        // first bank: determinant terms, |n|^2 terms, b x n and n x a
        cc3_mul u_det (.aclk, .en, .a(MA_W'(t_reg[k])), .b(MB_W'(p03_reg[k])),
                       .p(det_p[k]));
        cc3_mul u_nn  (.aclk, .en, .a(MA_W'(n_reg[k])), .b(MB_W'(n_reg[k])),
                       .p(nn_p[k]));
        cc3_mul u_bn0 (.aclk, .en, .a(MA_W'(n_reg[K2])), .b(MB_W'(b3_reg[K1])),
                       .p(bn_p[k][0]));
        cc3_mul u_bn1 (.aclk, .en, .a(MA_W'(n_reg[K1])), .b(MB_W'(b3_reg[K2])),
                       .p(bn_p[k][1]));
        cc3_mul u_na0 (.aclk, .en, .a(MA_W'(n_reg[K1])), .b(MB_W'(a3_reg[K2])),
                       .p(na_p[k][0]));
        cc3_mul u_na1 (.aclk, .en, .a(MA_W'(n_reg[K2])), .b(MB_W'(a3_reg[K1])),
                       .p(na_p[k][1]));

        // second bank: |a|^2 (b x n) and |b|^2 (n x a)
        cc3_mul u_num0 (.aclk, .en, .a(bn_reg[k]), .b(MB_W'(aa7_reg)),
                        .p(num_p[k][0]));
        cc3_mul u_num1 (.aclk, .en, .a(na_reg[k]), .b(MB_W'(bb7_reg)),
                        .p(num_p[k][1]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            aa_reg <= SQ_W'(asq_reg[0]) + SQ_W'(asq_reg[1]) + SQ_W'(asq_reg[2]);
            bb_reg <= SQ_W'(bsq_reg[0]) + SQ_W'(bsq_reg[1]) + SQ_W'(bsq_reg[2]);
        end
    end

    // zero normal: collinear or coincident points
    assign colin = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);

    // side data delay matching the first bank
    always_ff @(posedge aclk) begin
        if (en) begin
            maa_reg[0]  <= aa_reg;
            mbb_reg[0]  <= bb_reg;
            mp0_reg[0]  <= p03_reg;
            mcol_reg[0] <= colin;
            for (int i = 1; i < 3; i++) begin
                maa_reg[i]  <= maa_reg[i-1];
                mbb_reg[i]  <= mbb_reg[i-1];
                mp0_reg[i]  <= mp0_reg[i-1];
                mcol_reg[i] <= mcol_reg[i-1];
            end
        end
    end

    assign det_sum = det_p[0] + det_p[1] + det_p[2];

    // G7: reduce the first bank
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                bn_reg[k]  <= MA_W'(bn_p[k][0] - bn_p[k][1]);
                na_reg[k]  <= MA_W'(na_p[k][0] - na_p[k][1]);
                p07_reg[k] <= mp0_reg[2][k];
            end
            nn7_reg       <= NN_W'(nn_p[0] + nn_p[1] + nn_p[2]);
            fl7_reg.colin <= mcol_reg[2];
            fl7_reg.sing  <= (det_sum == '0);
            aa7_reg       <= maa_reg[2];
            bb7_reg       <= mbb_reg[2];
        end
    end

    // side data delay matching the second bank
    always_ff @(posedge aclk) begin
        if (en) begin
            nnd_reg[0] <= nn7_reg;
            fld_reg[0] <= fl7_reg;
            p0d_reg[0] <= p07_reg;
            for (int i = 1; i < 3; i++) begin
                nnd_reg[i] <= nnd_reg[i-1];
                fld_reg[i] <= fld_reg[i-1];
                p0d_reg[i] <= p0d_reg[i-1];
            end
        end
    end

    // G11 / G12: numerator, then sign and magnitude
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k]        <= num_p[k][0] + num_p[k][1];
                p011_reg[k]       <= p0d_reg[2][k];
                mag_reg[k]        <= num_reg[k][MP_W-1] ? MAG_W'(-num_reg[k])
                                                        : MAG_W'(num_reg[k]);
                tag_reg[k].p0     <= p011_reg[k];
                tag_reg[k].neg    <= num_reg[k][MP_W-1];
                tag_reg[k].flags  <= fl11_reg;
            end
            nn11_reg <= nnd_reg[2];
            fl11_reg <= fld_reg[2];
            nn12_reg <= nn11_reg;
        end
    end

    assign mag = mag_reg;
    assign nn  = nn12_reg;
    assign tag = tag_reg;

endmodule

FILE: src/cc3_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// q = floor((2 mag + 2 nn) / (4 nn)), i.e. mag / (2 nn) rounded half away.
// big flags a quotient that does not fit in QB bits.
module cc3_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic        [cc3_pkg::MAG_W-1:0]  mag,
    input  logic        [cc3_pkg::NN_W-1:0]   nn,
    input  cc3_pkg::tag_t                     tag_in,
    output logic        [cc3_pkg::QB-1:0]     q,
    output logic                              big,
    output cc3_pkg::tag_t                     tag_out
);
    import cc3_pkg::*;

    logic [NUMER_W-1:0] numer;
    logic [REM_W-1:0]   rem0_reg;
    logic [QB-1:0]      low0_reg;
    logic [DEN_W-1:0]   den0_reg;
    tag_t               tag0_reg;

    logic [REM_W-1:0]   rem_reg [QB];
    logic [QB-1:0]      low_reg [QB];
    logic [DEN_W-1:0]   den_reg [QB];
    logic [QB-1:0]      q_reg [QB];
    logic               big_reg [QB];
    tag_t               tag_reg [QB];

    assign numer = NUMER_W'({mag, 1'b0}) + NUMER_W'({nn, 1'b0});

    // entry stage: split the numerator at the top quotient bit
    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= REM_W'(numer[NUMER_W-1:QB]);
            low0_reg <= numer[QB-1:0];
            den0_reg <= DEN_W'({nn, 2'b00});
            tag0_reg <= tag_in;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        logic [REM_W-1:0] rem_p;
        logic [QB-1:0]    low_p;
        logic [DEN_W-1:0] den_p;
        logic [QB-1:0]    q_p;
        logic             big_p;
        tag_t             tag_p;
        logic [REM_W:0]   trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_p = rem0_reg;
            assign low_p = low0_reg;
            assign den_p = den0_reg;
            assign q_p   = '0;
            assign big_p = (rem0_reg >= den0_reg);
            assign tag_p = tag0_reg;
        end else begin : g_next
            assign rem_p = rem_reg[s-1];
            assign low_p = low_reg[s-1];
            assign den_p = den_reg[s-1];
            assign q_p   = q_reg[s-1];
            assign big_p = big_reg[s-1];
            assign tag_p = tag_reg[s-1];
        end

        assign trial = {rem_p, low_p[QB-1]};
        assign ge    = (trial >= {1'b0, den_p});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= ge ? REM_W'(trial - {1'b0, den_p}) : REM_W'(trial);
                low_reg[s] <= {low_p[QB-2:0], 1'b0};
                den_reg[s] <= den_p;
                q_reg[s]   <= {q_p[QB-2:0], ge};
                big_reg[s] <= big_p;
                tag_reg[s] <= tag_p;
            end
        end
    end

    assign q       = q_reg[QB-1];
    assign big     = big_reg[QB-1];
    assign tag_out = tag_reg[QB-1];

endmodule

FILE: src/circle_center_three_points_3d.sv
// Circle center through three 3D points, signed Q15.16 in and out.
// Input channel s_*: one transfer carries the three points, nine 32-bit
// coordinates. Result channel m_*: the center in m_tdata and a status code
// in m_tuser (ok, singular system, collinear points, saturated). Collinear
// and singular inputs return a zero center.
// Throughput: one item per cycle while s_tready is high. Pipeline from the
// input transfer to m_tvalid: 12 stages of products and sums, set by the
// 102 x 68 split multipliers in two banks, 63 divider stages (an entry
// stage, then one quotient bit each), one add stage, then the output register.
// Reset (aresetn low, synchronous) empties the pipeline and the output.
// When the receiver stalls, the result holds in the output register and
// one more result is caught in a skid register; the pipeline then freezes
// and s_tready drops until the receiver takes a transfer. Nothing is lost
// or repeated.
module circle_center_three_points_3d (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z
    input  logic [cc3_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // center_x, center_y, center_z
    output logic [cc3_pkg::OUT_W-1:0]   m_tdata,
    // status
    output logic [1:0]                  m_tuser
);
    import cc3_pkg::*;

    logic                 en;
    coord_t               pt [3][3];
    logic [MAG_W-1:0]     mag [3];
    logic [NN_W-1:0]      nn;
    tag_t                 gtag [3];
    logic [QB-1:0]        q [3];
    logic                 big [3];
    tag_t                 dtag [3];

    logic [PIPE_LAT-1:0]     vld_reg;
    logic signed [SUM_W-1:0] s_reg [3];
    logic                    big_reg [3];
    logic                    neg_reg [3];
    flags_t                  fl_reg;

    result_t res;
    result_t out_reg, out_next, skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    // pipeline advances unless the skid register is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    for (genvar i = 0; i < 3; i++) begin : g_pt
        for (genvar k = 0; k < 3; k++) begin : g_co
            assign pt[i][k] = s_tdata[(i*3+k)*COORD_W +: COORD_W];
        end
    end

    cc3_geom u_geom (
        .aclk, .en, .pt, .mag, .nn, .tag(gtag)
    );

    for (genvar k = 0; k < 3; k++) begin : g_div
        cc3_div u_div (
            .aclk, .en, .mag(mag[k]), .nn, .tag_in(gtag[k]),
            .q(q[k]), .big(big[k]), .tag_out(dtag[k])
        );
    end

    // valid bits along the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // offset back to absolute position
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= dtag[k].neg
                    ? SUM_W'(dtag[k].p0) - $signed({{(SUM_W-QB){1'b0}}, q[k]})
                    : SUM_W'(dtag[k].p0) + $signed({{(SUM_W-QB){1'b0}}, q[k]});
                big_reg[k] <= big[k];
                neg_reg[k] <= dtag[k].neg;
            end
            fl_reg <= dtag[0].flags;
        end
    end

    // clamp and status
    always_comb begin
        logic sat;
        sat = 1'b0;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            if (big_reg[k]) begin
                res.center[k] = neg_reg[k] ? COORD_W'(OUT_MIN) : COORD_W'(OUT_MAX);
                sat = 1'b1;
            end else if (s_reg[k] > OUT_MAX) begin
                res.center[k] = COORD_W'(OUT_MAX);
                sat = 1'b1;
            end else if (s_reg[k] < OUT_MIN) begin
                res.center[k] = COORD_W'(OUT_MIN);
                sat = 1'b1;
            end else begin
                res.center[k] = COORD_W'(s_reg[k]);
            end
        end
        if (fl_reg.colin) begin
            res = '0;
            res.status = ST_COLLINEAR;
        end else if (fl_reg.sing) begin
            res = '0;
            res.status = ST_SINGULAR;
        end else begin
            res.status = sat ? ST_SATURATED : ST_OK;
        end
    end

    // output register plus skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !m_tready) begin
            if (en && vld_reg[PIPE_LAT-1]) begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = vld_reg[PIPE_LAT-1];
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.center;
    assign m_tuser  = out_reg.status;

endmodule

FILE: src/cc3_check.sv
module cc3_check (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cc3_pkg::OUT_W-1:0]   m_tdata,
    input logic [1:0]                  m_tuser
);
    import cc3_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // degenerate inputs give a zero center
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_COLLINEAR || m_tuser == ST_SINGULAR)
        |-> m_tdata == '0)
        else $error("nonzero center with degenerate status");

    // input refused only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked with empty output");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind circle_center_three_points_3d cc3_check u_cc3_check (.*);
